### hdl/fimc_pkg.sv
`default_nettype none

package fimc_pkg;

    // fixed point format of every mass
    localparam int FRAC_BITS  = 24;
    localparam int MZ_W       = 14 + FRAC_BITS;
    localparam int NUM_W      = MZ_W + 1;

    // charge handling
    localparam int MAX_CHARGE = 8;
    localparam int CHG_IN_W   = 4;
    localparam int CHG_W      = $clog2(MAX_CHARGE + 1);

    // register widths
    localparam int OFF_W      = 30;
    localparam int SMALL_W    = 26;
    localparam int CFG_W      = 30;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = CHG_W + SMALL_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CO       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NH3      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CO_M_H2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NH2      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PROTON   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HYDROGEN = 3'd5;

    // register reset values
    localparam logic [OFF_W-1:0]   RST_CO       = 30'd469676729;
    localparam logic [OFF_W-1:0]   RST_NH3      = 30'd285658090;
    localparam logic [OFF_W-1:0]   RST_CO_M_H2  = 30'd435859732;
    localparam logic [OFF_W-1:0]   RST_NH2      = 30'd268749595;
    localparam logic [SMALL_W-1:0] RST_PROTON   = 26'd16899296;
    localparam logic [SMALL_W-1:0] RST_HYDROGEN = 26'd16908499;

    // ion series codes
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_B  = 3'd0;
    localparam logic [OP_W-1:0] OP_Y  = 3'd1;
    localparam logic [OP_W-1:0] OP_A  = 3'd2;
    localparam logic [OP_W-1:0] OP_C  = 3'd3;
    localparam logic [OP_W-1:0] OP_X  = 3'd4;
    localparam logic [OP_W-1:0] OP_Z  = 3'd5;
    localparam logic [OP_W-1:0] OP_Z1 = 3'd6;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // pipelined divider by charge
    localparam int DIV_BPS    = 4;
    localparam int DIV_STAGES = (NUM_W + DIV_BPS - 1) / DIV_BPS;
    localparam int DVD_W      = DIV_STAGES * DIV_BPS;

    typedef struct packed {
        logic [OFF_W-1:0]   co;
        logic [OFF_W-1:0]   nh3;
        logic [OFF_W-1:0]   co_m_h2;
        logic [OFF_W-1:0]   nh2;
        logic [SMALL_W-1:0] proton;
        logic [SMALL_W-1:0] hydrogen;
    } cfg_t;

    // one classified item waiting for the back end
    typedef struct packed {
        logic [MZ_W-1:0]   mass;
        logic [PROD_W-1:0] padd;
        logic [CHG_W-1:0]  chg;
    } qent_t;

endpackage

`default_nettype wire

### hdl/fimc_front.sv
`default_nettype none

module fimc_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [fimc_pkg::OP_W-1:0]      op,
    input  wire logic [fimc_pkg::MZ_W-1:0]      prefix_mass,
    input  wire logic [fimc_pkg::MZ_W-1:0]      suffix_mass,
    input  wire logic [fimc_pkg::CHG_IN_W-1:0]  charge,
    input  wire fimc_pkg::cfg_t                 cfg,
    input  wire logic [fimc_pkg::QCNT_W-1:0]    q_cnt,
    output logic                                push,
    output fimc_pkg::qent_t                     push_data
);

    localparam int CW = fimc_pkg::MZ_W + 1;

    logic                          accept;
    logic [fimc_pkg::MZ_W-1:0]     base;
    logic [fimc_pkg::OFF_W-1:0]    off;
    logic                          is_sub;
    logic [CW-1:0]                 sum;
    logic [CW-1:0]                 diff;
    logic [fimc_pkg::MZ_W-1:0]     mass1;
    logic [31:0]                   chg_wide;
    logic [fimc_pkg::CHG_W-1:0]    chg1;
    logic [fimc_pkg::PROD_W-1:0]   prod1;
    logic [CW-1:0]                 hsum;
    logic [fimc_pkg::MZ_W-1:0]     mass2;
    logic [fimc_pkg::QCNT_W+1:0]   credit;

    logic                          v1_reg;
    logic                          add_h_reg;
    fimc_pkg::qent_t               s1_reg;
    fimc_pkg::qent_t               s1_next;
    logic                          v2_reg;
    fimc_pkg::qent_t               s2_reg;
    fimc_pkg::qent_t               s2_next;

    // hold off new beats while the queue could not take everything in flight
    assign credit = {2'b00, q_cnt} + (fimc_pkg::QCNT_W + 2)'(v1_reg)
                  + (fimc_pkg::QCNT_W + 2)'(v2_reg);
    assign busy   = (credit >= (fimc_pkg::QCNT_W + 2)'(fimc_pkg::QDEPTH));
    assign accept = start && !busy;

    // series decode: which mass, which offset, add or subtract
    always_comb
    begin
        base   = suffix_mass;
        off    = '0;
        is_sub = 1'b0;
        unique case (op)
            fimc_pkg::OP_B:
            begin
                base = prefix_mass;
            end
            fimc_pkg::OP_Y:
            begin
                base = suffix_mass;
            end
            fimc_pkg::OP_A:
            begin
                base   = prefix_mass;
                off    = cfg.co;
                is_sub = 1'b1;
            end
            fimc_pkg::OP_C:
            begin
                base = prefix_mass;
                off  = cfg.nh3;
            end
            fimc_pkg::OP_X:
            begin
                off = cfg.co_m_h2;
            end
            fimc_pkg::OP_Z, fimc_pkg::OP_Z1:
            begin
                off    = cfg.nh2;
                is_sub = 1'b1;
            end
            default:
            begin
                base = '0;
            end
        endcase
    end

    // offset with clamp at zero and saturation at full scale
    assign sum  = {1'b0, base} + CW'(off);
    assign diff = {1'b0, base} - CW'(off);

    always_comb
    begin
        if (is_sub)
        begin
            mass1 = diff[CW-1] ? '0 : diff[fimc_pkg::MZ_W-1:0];
        end
        else
        begin
            mass1 = sum[CW-1] ? '1 : sum[fimc_pkg::MZ_W-1:0];
        end
    end

    // charge clamp: zero counts as one, top limited to the maximum
    always_comb
    begin
        chg_wide = 32'(charge);
        if (chg_wide == 32'd0)
        begin
            chg_wide = 32'd1;
        end
        else if (chg_wide > 32'(fimc_pkg::MAX_CHARGE))
        begin
            chg_wide = 32'(fimc_pkg::MAX_CHARGE);
        end
    end

    assign chg1  = chg_wide[fimc_pkg::CHG_W-1:0];
    assign prod1 = fimc_pkg::PROD_W'((chg1 - fimc_pkg::CHG_W'(1)) * cfg.proton);

    always_comb
    begin
        s1_next.mass = mass1;
        s1_next.padd = prod1;
        s1_next.chg  = chg1;
    end

    // second stage: hydrogen for the z+1 series
    assign hsum = {1'b0, s1_reg.mass} + CW'(cfg.hydrogen);
    assign mass2 = add_h_reg ? (hsum[CW-1] ? '1 : hsum[fimc_pkg::MZ_W-1:0])
                             : s1_reg.mass;

    always_comb
    begin
        s2_next      = s1_reg;
        s2_next.mass = mass2;
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        s1_reg    <= s1_next;
        add_h_reg <= (op == fimc_pkg::OP_Z1);
        s2_reg    <= s2_next;
    end

    assign push      = v2_reg;
    assign push_data = s2_reg;

endmodule

`default_nettype wire

### hdl/fimc_queue.sv
`default_nettype none

module fimc_queue (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire fimc_pkg::qent_t              push_data,
    input  wire logic                         pop,
    output logic                              head_vld,
    output fimc_pkg::qent_t                   head,
    output logic [fimc_pkg::QCNT_W-1:0]       cnt
);

    fimc_pkg::qent_t                   mem_reg [fimc_pkg::QDEPTH];
    logic [fimc_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [fimc_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [fimc_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [fimc_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [fimc_pkg::QCNT_W-1:0]       cnt_reg;
    logic [fimc_pkg::QCNT_W-1:0]       cnt_next;
    logic                              do_pop;

    assign do_pop   = pop && (cnt_reg != '0);
    assign head_vld = (cnt_reg != '0);
    assign head     = mem_reg[rd_ptr_reg];
    assign cnt      = cnt_reg;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == fimc_pkg::QPTR_W'(fimc_pkg::QDEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == fimc_pkg::QPTR_W'(fimc_pkg::QDEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + fimc_pkg::QCNT_W'(push) - fimc_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### hdl/fimc_back.sv
`default_nettype none

module fimc_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       head_vld,
    input  wire fimc_pkg::qent_t            head,
    output logic                            pop,
    output logic                            done,
    output logic [fimc_pkg::MZ_W-1:0]       ion_mz
);

    typedef struct packed {
        logic [fimc_pkg::CHG_W-1:0] rem;
        logic [fimc_pkg::DVD_W-1:0] dvd;
        logic [fimc_pkg::DVD_W-1:0] quo;
        logic [fimc_pkg::CHG_W-1:0] dvs;
    } div_t;

    // DIV_BPS restoring steps of the divide by charge
    function automatic div_t div_step(input div_t s);
        div_t                       o;
        logic [fimc_pkg::CHG_W:0]   r;
        o = s;
        for (int i = 0; i < fimc_pkg::DIV_BPS; i++)
        begin
            r     = {o.rem, o.dvd[fimc_pkg::DVD_W-1]};
            o.dvd = {o.dvd[fimc_pkg::DVD_W-2:0], 1'b0};
            if (r >= {1'b0, o.dvs})
            begin
                r     = r - {1'b0, o.dvs};
                o.quo = {o.quo[fimc_pkg::DVD_W-2:0], 1'b1};
            end
            else
            begin
                o.quo = {o.quo[fimc_pkg::DVD_W-2:0], 1'b0};
            end
            o.rem = r[fimc_pkg::CHG_W-1:0];
        end
        return o;
    endfunction

    logic [fimc_pkg::NUM_W-1:0]        num;
    div_t                              ld;
    div_t                              st_reg  [fimc_pkg::DIV_STAGES+1];
    logic [fimc_pkg::DIV_STAGES:0]     vld_reg;
    logic [fimc_pkg::DVD_W-1:0]        q;
    logic [fimc_pkg::MZ_W-1:0]         mz_next;
    logic                              done_reg;
    logic [fimc_pkg::MZ_W-1:0]         mz_reg;

    // the back end never stalls, so the head is taken as soon as it shows
    assign pop = head_vld;

    // numerator: mass plus the extra protons
    assign num = {1'b0, head.mass} + fimc_pkg::NUM_W'(head.padd);

    always_comb
    begin
        ld.rem = '0;
        ld.dvd = fimc_pkg::DVD_W'(num);
        ld.quo = '0;
        ld.dvs = head.chg;
    end

    // divider pipeline, one group of quotient bits per stage
    always_ff @(posedge clk)
    begin
        st_reg[0] <= ld;
        for (int k = 0; k < fimc_pkg::DIV_STAGES; k++)
        begin
            st_reg[k+1] <= div_step(st_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[fimc_pkg::DIV_STAGES-1:0], head_vld};
            done_reg <= vld_reg[fimc_pkg::DIV_STAGES];
        end
    end

    // saturate the quotient into the result range
    assign q       = st_reg[fimc_pkg::DIV_STAGES].quo;
    assign mz_next = (|q[fimc_pkg::DVD_W-1:fimc_pkg::MZ_W]) ? '1 : q[fimc_pkg::MZ_W-1:0];

    always_ff @(posedge clk)
    begin
        mz_reg <= mz_next;
    end

    assign done   = done_reg;
    assign ion_mz = mz_reg;

endmodule

`default_nettype wire

### hdl/fragment_ion_mass_calc.sv
// throughput: one beat per cycle while busy is low; the front end and the
// 10-stage divider pipeline each take a new beat every cycle, the queue between
// them refills each cycle
// the receiver cannot stall; done is high for exactly one cycle per result
// reset (rst_n low, asynchronous) empties the pipeline and queue and loads
// the offset and mass registers with their default values
`default_nettype none

module fragment_ion_mass_calc (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [fimc_pkg::OP_W-1:0]        op,
    input  wire logic [fimc_pkg::MZ_W-1:0]        prefix_mass,
    input  wire logic [fimc_pkg::MZ_W-1:0]        suffix_mass,
    input  wire logic [fimc_pkg::CHG_IN_W-1:0]    charge,
    output logic                                  done,
    output logic [fimc_pkg::MZ_W-1:0]             ion_mz,
    input  wire logic                             cfg_we,
    input  wire logic [fimc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fimc_pkg::CFG_W-1:0]       cfg_data
);

    fimc_pkg::cfg_t                    cfg_reg;
    fimc_pkg::cfg_t                    cfg_next;
    logic                              push;
    fimc_pkg::qent_t                   push_data;
    logic                              pop;
    logic                              head_vld;
    fimc_pkg::qent_t                   head;
    logic [fimc_pkg::QCNT_W-1:0]       q_cnt;

    // register writes; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                fimc_pkg::REG_CO:       cfg_next.co       = cfg_data;
                fimc_pkg::REG_NH3:      cfg_next.nh3      = cfg_data;
                fimc_pkg::REG_CO_M_H2:  cfg_next.co_m_h2  = cfg_data;
                fimc_pkg::REG_NH2:      cfg_next.nh2      = cfg_data;
                fimc_pkg::REG_PROTON:   cfg_next.proton   = cfg_data[fimc_pkg::SMALL_W-1:0];
                fimc_pkg::REG_HYDROGEN: cfg_next.hydrogen = cfg_data[fimc_pkg::SMALL_W-1:0];
                default:                cfg_next          = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.co       <= fimc_pkg::RST_CO;
            cfg_reg.nh3      <= fimc_pkg::RST_NH3;
            cfg_reg.co_m_h2  <= fimc_pkg::RST_CO_M_H2;
            cfg_reg.nh2      <= fimc_pkg::RST_NH2;
            cfg_reg.proton   <= fimc_pkg::RST_PROTON;
            cfg_reg.hydrogen <= fimc_pkg::RST_HYDROGEN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: take beats, pick mass and offset, work out proton term
    fimc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .prefix_mass (prefix_mass),
        .suffix_mass (suffix_mass),
        .charge      (charge),
        .cfg         (cfg_reg),
        .q_cnt       (q_cnt),
        .push        (push),
        .push_data   (push_data)
    );

    // short queue between front and back
    fimc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_vld  (head_vld),
        .head      (head),
        .cnt       (q_cnt)
    );

    // back end: numerator and divide by charge
    fimc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_vld (head_vld),
        .head     (head),
        .pop      (pop),
        .done     (done),
        .ion_mz   (ion_mz)
    );

    // the queue is never written while full
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_cnt == fimc_pkg::QCNT_W'(fimc_pkg::QDEPTH)))
        else $error("queue written while full");

    // an accepted beat reaches the queue after passing the front end stage registers
    a_front_latency : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 push)
        else $error("front end lost a beat");

    // every beat pushed into the queue comes out as a result on done
    a_back_latency : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ##13 done)
        else $error("back end lost a beat");

endmodule

`default_nettype wire
